// File: design/jls_pkg.sv
// shared constants for the jacobi laplace stencil sweep
package jls_pkg;

  localparam int MAX_WIDTH = 512;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int COL_W     = ADDR_W + 1;
  localparam int VAL_W     = 16;
  localparam int SUM_W     = VAL_W + 2;
  localparam int ROW_W     = 17;
  localparam int RW_W      = 10;
  localparam int IR_W      = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam int MIN_WIDTH = 3;

  localparam logic [RW_W-1:0] ROW_WIDTH_RST     = RW_W'(400);
  localparam logic [IR_W-1:0] INTERIOR_ROWS_RST = IR_W'(400);

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INTERIOR_ROWS = CFG_IDX_W'(1);

  // floor(x / 3) = (x * ceil(2^19 / 3)) >> 19, exact for x < 2^19
  localparam int RECIP3_SH = SUM_W + 1;
  localparam logic [SUM_W-1:0] RECIP3 = SUM_W'(((1 << RECIP3_SH) + 2) / 3);

endpackage

// File: design/jls_ram.sv
// generic simple dual-port ram with registered read
module jls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/jacobi_laplace_stencil_sweep.sv
// top level of the five-point jacobi sweep over a streamed grid
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata[15:0] cell_value
//  out_    | out | out_tvalid/tready  | tdata[15:0] new_value, tlast last_of_grid
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
// one beat per cycle sustained while the output is not stalled; a result passes
// the store read at accept, the stencil and divide-by-3 multiply in stage 1 and
// then the output register. the two line stores each give one read per beat,
// which sets the rate. rst_n is synchronous; it clears counters, the window,
// valid bits and the registers to 400 columns and 400 rows. a stalled output
// holds its beat while one more input beat is taken into the compute stage;
// after that in_tready drops until out_tready returns.
module jacobi_laplace_stencil_sweep (
  input  logic                          clk,
  input  logic                          rst_n,
  // cfg
  input  logic                          cfg_we,
  input  logic [jls_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [jls_pkg::CFG_W-1:0]     cfg_wdata,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [jls_pkg::VAL_W-1:0]     in_tdata,   // [15:0] cell_value
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [jls_pkg::VAL_W-1:0]     out_tdata,  // [15:0] new_value
  output logic                          out_tlast   // last_of_grid
);

  localparam int ADDR_W = jls_pkg::ADDR_W;
  localparam int COL_W  = jls_pkg::COL_W;
  localparam int VAL_W  = jls_pkg::VAL_W;
  localparam int SUM_W  = jls_pkg::SUM_W;
  localparam int ROW_W  = jls_pkg::ROW_W;

  typedef struct packed {
    logic              first;     // column 0
    logic              last_col;
    logic              emit;      // row counter past the two fill rows
    logic              last;      // final interior cell of the sweep
    logic [ADDR_W-1:0] col;       // upper store write address
    logic [VAL_W-1:0]  lower;     // incoming cell
    logic [VAL_W-1:0]  mid0;      // previous row, column 0
  } s1_t;

  // configuration registers
  logic [jls_pkg::RW_W-1:0] row_width_r;
  logic [jls_pkg::IR_W-1:0] interior_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r     <= jls_pkg::ROW_WIDTH_RST;
      interior_rows_r <= jls_pkg::INTERIOR_ROWS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        jls_pkg::CFG_ROW_WIDTH:     row_width_r     <= cfg_wdata[jls_pkg::RW_W-1:0];
        jls_pkg::CFG_INTERIOR_ROWS: interior_rows_r <= cfg_wdata[jls_pkg::IR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective width clamped to 3..MAX_WIDTH, rows of 0 act as 1
  logic [COL_W-1:0] eff_w;
  logic [ROW_W-1:0] last_row_idx;

  always_comb begin
    if (int'(row_width_r) < jls_pkg::MIN_WIDTH) begin
      eff_w = COL_W'(jls_pkg::MIN_WIDTH);
    end else if (int'(row_width_r) > jls_pkg::MAX_WIDTH) begin
      eff_w = COL_W'(jls_pkg::MAX_WIDTH);
    end else begin
      eff_w = COL_W'(row_width_r);
    end
    if (interior_rows_r == '0) begin
      last_row_idx = ROW_W'(2);
    end else begin
      last_row_idx = ROW_W'(interior_rows_r) + ROW_W'(1);
    end
  end

  // stage 0: accept, counters, store addressing
  logic [ADDR_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [VAL_W-1:0]  mid0_r;
  logic [ADDR_W-1:0] c;
  logic [COL_W-1:0]  c_plus1;
  logic              last_col, last_row;
  logic [ADDR_W-1:0] mid_raddr;
  logic              in_acc;

  s1_t  s1_r, s1_nxt;
  logic s1_v_r;
  logic s1_adv;

  assign in_tready = !s1_v_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    // a column counter at or past the row end acts as the last column
    if (COL_W'(col_r) >= eff_w) begin
      c = ADDR_W'(eff_w - COL_W'(1));
    end else begin
      c = col_r;
    end
    c_plus1  = COL_W'(c) + COL_W'(1);
    last_col = c_plus1 >= eff_w;
    last_row = row_r >= last_row_idx;
    // read ahead one column; at column 0 column 1 comes from the store
    mid_raddr = (c == '0) ? ADDR_W'(1) : c_plus1[ADDR_W-1:0];

    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + ROW_W'(1);
    end else begin
      col_nxt = c_plus1[ADDR_W-1:0];
      row_nxt = row_r;
    end

    s1_nxt.first    = (c == '0);
    s1_nxt.last_col = last_col;
    s1_nxt.emit     = row_r >= ROW_W'(2);
    s1_nxt.last     = last_row && last_col;
    s1_nxt.col      = c;
    s1_nxt.lower    = in_tdata;
    s1_nxt.mid0     = mid0_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      s1_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  // column 0 of the middle row is only ever written here, so a register copy is exact
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
      if (c == '0) begin
        mid0_r <= in_tdata;
      end
    end
  end

  // line stores
  logic [VAL_W-1:0] up_rd, mid_rd;
  logic [VAL_W-1:0] tap0_r, tap1_r, tap2_r;
  logic [VAL_W-1:0] tap0_nxt, tap1_nxt, tap2_nxt;

  jls_ram #(.WIDTH(VAL_W), .DEPTH(jls_pkg::MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_r.col),
    .wdata (tap1_nxt),
    .re    (in_acc),
    .raddr (c),
    .rdata (up_rd)
  );

  jls_ram #(.WIDTH(VAL_W), .DEPTH(jls_pkg::MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (in_acc),
    .waddr (c),
    .wdata (in_tdata),
    .re    (in_acc),
    .raddr (mid_raddr),
    .rdata (mid_rd)
  );

  // stage 1: three-tap window and stencil
  logic [SUM_W-1:0]     sum3, sum4;
  logic [2*SUM_W-1:0]   prod3;
  logic [VAL_W-1:0]     val;

  always_comb begin
    if (s1_r.first) begin
      tap0_nxt = '0;
      tap1_nxt = s1_r.mid0;
      tap2_nxt = mid_rd;
    end else begin
      tap0_nxt = tap1_r;
      tap1_nxt = tap2_r;
      tap2_nxt = s1_r.last_col ? '0 : mid_rd;
    end
    // edge columns: the one inner neighbor plus above and below
    sum3 = SUM_W'(s1_r.first ? tap2_nxt : tap0_nxt) + SUM_W'(up_rd) + SUM_W'(s1_r.lower);
    sum4 = SUM_W'(tap0_nxt) + SUM_W'(tap2_nxt) + SUM_W'(up_rd) + SUM_W'(s1_r.lower);
    prod3 = (2*SUM_W)'(sum3) * (2*SUM_W)'(jls_pkg::RECIP3);
    if (s1_r.first || s1_r.last_col) begin
      val = prod3[jls_pkg::RECIP3_SH +: VAL_W];
    end else begin
      val = sum4[SUM_W-1 -: VAL_W];
    end
  end

  // output register
  logic             out_v_r;
  logic [VAL_W-1:0] out_data_r;
  logic             out_last_r;

  assign s1_adv = s1_v_r && (!s1_r.emit || !out_v_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap0_r  <= '0;
      tap1_r  <= '0;
      tap2_r  <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        tap0_r <= tap0_nxt;
        tap1_r <= tap1_nxt;
        tap2_r <= tap2_nxt;
      end
      if (s1_adv && s1_r.emit) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_r.emit) begin
      out_data_r <= val;
      out_last_r <= s1_r.last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// File: design/jls_checker.sv
// port-level checks for the jacobi sweep, bound to the top level
module jls_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [jls_pkg::VAL_W-1:0] out_tdata,
  input logic                      out_tlast
);

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // input stalls only behind a stalled output beat
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output back-pressure");

  // a held output beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // a new result needs an earlier input beat, so none right after reset
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(rst_n))
    else $error("result appeared straight out of reset");

endmodule

bind jacobi_laplace_stencil_sweep jls_checker u_jls_checker (.*);
